/* hw/rtl/ucbef_pkg.sv */
// Shared types and constants for the bulk endpoint finder.
// Descriptor type codes, field masks and the result record.
// No dependencies.
`default_nettype none

package ucbef_pkg;

  // Descriptor type codes
  localparam logic [7:0] TYPE_CONFIG    = 8'h02;
  localparam logic [7:0] TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;

  // Endpoint fields
  localparam logic [7:0] DIR_IN_BIT     = 8'h80;
  localparam logic [1:0] XFER_BULK      = 2'h2;
  localparam logic [15:0] DEFAULT_SIZE  = 16'd64;

  // Length limits
  localparam logic [7:0] MIN_DESC_LEN   = 8'd2;
  localparam logic [7:0] MIN_CONFIG_LEN = 8'd9;
  localparam logic [7:0] MIN_EP_LEN     = 8'd7;
  localparam logic [7:0] DEFAULT_CONFIG = 8'd1;

  // Body bytes two to five of the current descriptor
  localparam int BODY_BYTES = 4;

  typedef struct packed {
    logic        found;
    logic [7:0]  in_endpoint;
    logic [15:0] in_packet_size;
    logic [7:0]  out_endpoint;
    logic [15:0] out_packet_size;
    logic [7:0]  config_value;
  } ucbef_result_t;

endpackage

`default_nettype wire

/* hw/rtl/ucbef_parser.sv */
// Descriptor walker: holds the parse state and folds in one byte per step.
// Produces the result record for a final byte from the updated state.
// Depends on ucbef_pkg.
`default_nettype none

module ucbef_parser
  import ucbef_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic          is_last,
  output ucbef_result_t      result
);

  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  desc_length, desc_length_next;
  logic [7:0]  desc_type, desc_type_next;
  logic [7:0]  body [BODY_BYTES];
  logic [7:0]  body_next [BODY_BYTES];
  logic [7:0]  current_alt, current_alt_next;
  logic        stopped, stopped_next;
  logic [7:0]  best_in_addr, best_in_addr_next;
  logic [7:0]  best_out_addr, best_out_addr_next;
  logic [15:0] best_in_size, best_in_size_next;
  logic [15:0] best_out_size, best_out_size_next;
  logic [7:0]  chosen_config, chosen_config_next;
  logic [15:0] ep_size;
  logic [1:0]  body_idx;
  logic        commit;

  assign body_idx = 2'(byte_position[1:0] - 2'd2);

  // Fold the byte into the descriptor, then commit a completed one
  always_comb begin
    byte_position_next = byte_position;
    desc_length_next   = desc_length;
    desc_type_next     = desc_type;
    body_next          = body;
    current_alt_next   = current_alt;
    stopped_next       = stopped;
    best_in_addr_next  = best_in_addr;
    best_out_addr_next = best_out_addr;
    best_in_size_next  = best_in_size;
    best_out_size_next = best_out_size;
    chosen_config_next = chosen_config;
    commit             = 1'b0;

    if (!stopped) begin
      if (byte_position == 8'd0 && data_byte < MIN_DESC_LEN) begin
        // Short length ends parsing unless the stream ends here
        if (!is_last) begin
          stopped_next = 1'b1;
        end
      end else begin
        if (byte_position == 8'd0) begin
          desc_length_next = data_byte;
          for (int i = 0; i < BODY_BYTES; i++) begin
            body_next[i] = 8'd0;
          end
        end else if (byte_position == 8'd1) begin
          desc_type_next = data_byte;
        end else if (byte_position inside {[8'd2:8'd5]}) begin
          body_next[body_idx] = data_byte;
        end
        if (8'(byte_position + 8'd1) == desc_length_next) begin
          commit             = 1'b1;
          byte_position_next = 8'd0;
        end else begin
          byte_position_next = 8'(byte_position + 8'd1);
        end
      end
    end

    ep_size = {body_next[3], body_next[2]};
    if (ep_size == 16'd0) begin
      ep_size = DEFAULT_SIZE;
    end

    if (commit) begin
      if (desc_type_next == TYPE_CONFIG && desc_length_next >= MIN_CONFIG_LEN) begin
        chosen_config_next = (body_next[3] != 8'd0) ? body_next[3] : DEFAULT_CONFIG;
      end else if (desc_type_next == TYPE_INTERFACE &&
                   desc_length_next >= MIN_CONFIG_LEN) begin
        current_alt_next = body_next[1];
      end else if (desc_type_next == TYPE_ENDPOINT && desc_length_next >= MIN_EP_LEN &&
                   current_alt == 8'd0) begin
        if (body_next[1][1:0] == XFER_BULK) begin
          if ((body_next[0] & DIR_IN_BIT) != 8'd0) begin
            best_in_addr_next = body_next[0];
            best_in_size_next = ep_size;
          end else begin
            best_out_addr_next = body_next[0];
            best_out_size_next = ep_size;
          end
        end
      end
    end
  end

  // Build the record from the state this byte leaves
  always_comb begin
    result.found = (best_in_addr_next != 8'd0) && (best_out_addr_next != 8'd0);
    result.in_endpoint     = result.found ? best_in_addr_next  : 8'd0;
    result.in_packet_size  = result.found ? best_in_size_next  : 16'd0;
    result.out_endpoint    = result.found ? best_out_addr_next : 8'd0;
    result.out_packet_size = result.found ? best_out_size_next : 16'd0;
    result.config_value    = chosen_config_next;
  end

  // Advance the state; a final byte returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      byte_position <= 8'd0;
      desc_length   <= 8'd0;
      desc_type     <= 8'd0;
      for (int i = 0; i < BODY_BYTES; i++) begin
        body[i] <= 8'd0;
      end
      current_alt   <= 8'd0;
      stopped       <= 1'b0;
      best_in_addr  <= 8'd0;
      best_out_addr <= 8'd0;
      best_in_size  <= 16'd0;
      best_out_size <= 16'd0;
      chosen_config <= DEFAULT_CONFIG;
    end else if (step) begin
      byte_position <= byte_position_next;
      desc_length   <= desc_length_next;
      desc_type     <= desc_type_next;
      body          <= body_next;
      current_alt   <= current_alt_next;
      stopped       <= stopped_next;
      best_in_addr  <= best_in_addr_next;
      best_out_addr <= best_out_addr_next;
      best_in_size  <= best_in_size_next;
      best_out_size <= best_out_size_next;
      chosen_config <= chosen_config_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/usb_config_bulk_endpoint_finder_unit.sv */
// Bulk endpoint finder for a USB configuration descriptor stream.
// Item channel: item_valid/item_stall with data_byte and is_last, one byte
//   of the descriptor stream per transaction; is_last marks the final byte.
// Result channel: result_valid/result_stall with found, the bulk IN and OUT
//   endpoint addresses and packet sizes, and config_value. One result
//   transaction follows each final byte; other bytes produce none.
// Throughput: one byte per clock while item_stall is low. A byte accepted
//   sits in the input register, is parsed into the parse state, and for a
//   final byte the result is then captured in the result register.
//   The rate is set by the combinational descriptor update between the input
//   register and the parse state / result register.
// Stall: non-final bytes keep flowing while a result waits. A final byte
//   waits in the input register only while the result register is full and
//   stalled; item_stall is raised for exactly that case.
// Reset (rst, synchronous): empties both registers and returns the parse
//   state to its start, configuration value 1. After each final byte the
//   parse state returns to the same start for the next stream.
// Depends on ucbef_pkg and ucbef_parser.
`default_nettype none

module usb_config_bulk_endpoint_finder_unit
  import ucbef_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        is_last,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             found,
  output logic [7:0]       in_endpoint,
  output logic [15:0]      in_packet_size,
  output logic [7:0]       out_endpoint,
  output logic [15:0]      out_packet_size,
  output logic [7:0]       config_value
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_last;
  logic          out_free;
  logic          s1_take;
  logic          item_accept;
  ucbef_result_t step_result;
  ucbef_result_t result;

  assign out_free    = !result_valid || !result_stall;
  assign s1_take     = s1_valid && (!s1_last || out_free);
  assign item_stall  = s1_valid && !s1_take;
  assign item_accept = item_valid && !item_stall;

  // Input register: load a new transaction or drain the parsed one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_byte <= data_byte;
      s1_last <= is_last;
    end
  end

  ucbef_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_take),
    .data_byte (s1_byte),
    .is_last   (s1_last),
    .result    (step_result)
  );

  // Result register: capture at a final byte, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_take && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_last) begin
      result <= step_result;
    end
  end

  assign found           = result.found;
  assign in_endpoint     = result.in_endpoint;
  assign in_packet_size  = result.in_packet_size;
  assign out_endpoint    = result.out_endpoint;
  assign out_packet_size = result.out_packet_size;
  assign config_value    = result.config_value;

`ifndef SYNTHESIS
  // Only a final byte facing a blocked result register holds the input
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && s1_last && result_valid && result_stall)
    else $error("item_stall raised without a blocked final byte");

  // A miss reports empty endpoint fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> in_endpoint == 8'd0 && out_endpoint == 8'd0 &&
      in_packet_size == 16'd0 && out_packet_size == 16'd0)
    else $error("endpoint fields set on a miss");

  // A hit has an IN address, an OUT address and nonzero sizes
  a_hit_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> in_endpoint[7] && !out_endpoint[7] &&
      out_endpoint != 8'd0 && in_packet_size != 16'd0 && out_packet_size != 16'd0)
    else $error("malformed endpoint pair");

  // Configuration value is never zero
  a_config_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> config_value != 8'd0)
    else $error("configuration value of zero");

  // A parsed final byte always produces a result
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    s1_take && s1_last |=> result_valid)
    else $error("final byte without a result");
`endif

endmodule

`default_nettype wire
